>>> src/lbps_pkg.sv
`timescale 1ns / 1ps

package lbps_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_LEDS_DEF  = 4;
    localparam int MAX_SLOTS_DEF = 10;

    // Field widths of one input item and one result item.
    localparam int OP_W       = 3;
    localparam int LED_IN_W   = 2;
    localparam int SLOT_IN_W  = 4;
    localparam int DUR_W      = 16;
    localparam int COUNT_IN_W = 4;
    localparam int PINS_W     = 4;

    // Stream data widths, fields packed from bit 0 and padded to bytes.
    localparam int IN_FIELDS_W = OP_W + LED_IN_W + SLOT_IN_W + DUR_W + COUNT_IN_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((PINS_W + 7) / 8) * 8;

    // Clamped slot count carried to the back end; holds up to 31.
    localparam int CMD_CNT_W = COUNT_IN_W + 1;

    // Command queue between front and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_ON      = 3'd1,
        OP_OFF     = 3'd2,
        OP_TOGGLE  = 3'd3,
        OP_ALL_ON  = 3'd4,
        OP_ALL_OFF = 3'd5,
        OP_WRITE   = 3'd6,
        OP_BLINK   = 3'd7
    } t_op;

    // Command kinds after classification; K_NONE only reports the pins.
    typedef enum logic [3:0] {
        K_TICK,
        K_ON,
        K_OFF,
        K_TOGGLE,
        K_ALL_ON,
        K_ALL_OFF,
        K_WRITE,
        K_BLINK,
        K_NONE
    } t_kind;

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_ON,
        MODE_BLINK
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK_CALC,
        S_TICK_LOAD,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_kind                  kind;
        logic [LED_IN_W-1:0]    led;
        logic [SLOT_IN_W-1:0]   slot;
        logic [DUR_W-1:0]       duration;
        logic [CMD_CNT_W-1:0]   count;
    } t_cmd;

endpackage

>>> src/lbps_front.sv
`timescale 1ns / 1ps

module lbps_front #(
    parameter int NUM_LEDS  = lbps_pkg::NUM_LEDS_DEF,
    parameter int MAX_SLOTS = lbps_pkg::MAX_SLOTS_DEF
) (
    input  logic                            i_tvalid,
    output logic                            o_tready,
    input  logic [lbps_pkg::IN_TDATA_W-1:0] i_tdata,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output lbps_pkg::t_cmd                  o_q_cmd
);

    localparam int CW = lbps_pkg::CMD_CNT_W;

    lbps_pkg::t_op                    w_op;
    logic [lbps_pkg::LED_IN_W-1:0]    w_led;
    logic [lbps_pkg::SLOT_IN_W-1:0]   w_slot;
    logic [lbps_pkg::DUR_W-1:0]       w_dur;
    logic [lbps_pkg::COUNT_IN_W-1:0]  w_count;
    logic                             w_led_ok;
    logic                             w_slot_ok;
    logic [CW-1:0]                    w_cnt_clamped;

    // Unpack the fields, lowest field first.
    assign w_op    = lbps_pkg::t_op'(i_tdata[2:0]);
    assign w_led   = i_tdata[4:3];
    assign w_slot  = i_tdata[8:5];
    assign w_dur   = i_tdata[24:9];
    assign w_count = i_tdata[28:25];

    assign w_led_ok  = CW'(w_led) < CW'(NUM_LEDS);
    assign w_slot_ok = CW'(w_slot) < CW'(MAX_SLOTS);

    always_comb begin
        if (CW'(w_count) > CW'(MAX_SLOTS)) begin
            w_cnt_clamped = CW'(MAX_SLOTS);
        end else if (w_count == '0) begin
            w_cnt_clamped = CW'(1);
        end else begin
            w_cnt_clamped = CW'(w_count);
        end
    end

    always_comb begin
        o_q_cmd.led      = w_led;
        o_q_cmd.slot     = w_slot;
        o_q_cmd.duration = w_dur;
        o_q_cmd.count    = w_cnt_clamped;
        case (w_op)
            lbps_pkg::OP_TICK:    o_q_cmd.kind = lbps_pkg::K_TICK;
            lbps_pkg::OP_ON:      o_q_cmd.kind = w_led_ok ? lbps_pkg::K_ON : lbps_pkg::K_NONE;
            lbps_pkg::OP_OFF:     o_q_cmd.kind = w_led_ok ? lbps_pkg::K_OFF : lbps_pkg::K_NONE;
            lbps_pkg::OP_TOGGLE:  o_q_cmd.kind = w_led_ok ? lbps_pkg::K_TOGGLE
                                                          : lbps_pkg::K_NONE;
            lbps_pkg::OP_ALL_ON:  o_q_cmd.kind = lbps_pkg::K_ALL_ON;
            lbps_pkg::OP_ALL_OFF: o_q_cmd.kind = lbps_pkg::K_ALL_OFF;
            lbps_pkg::OP_WRITE:   o_q_cmd.kind = (w_led_ok && w_slot_ok) ? lbps_pkg::K_WRITE
                                                                        : lbps_pkg::K_NONE;
            lbps_pkg::OP_BLINK:   o_q_cmd.kind = w_led_ok ? lbps_pkg::K_BLINK
                                                          : lbps_pkg::K_NONE;
            default:              o_q_cmd.kind = lbps_pkg::K_NONE;
        endcase
    end

    assign o_tready = !i_q_full;
    assign o_q_push = i_tvalid && !i_q_full;

endmodule

>>> src/lbps_queue.sv
`timescale 1ns / 1ps

module lbps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lbps_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output lbps_pkg::t_cmd o_head
);

    localparam int DEPTH = lbps_pkg::QUEUE_DEPTH;
    localparam int PW    = lbps_pkg::QPTR_W;

    lbps_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PW:0]    r_count,  n_count;

    assign o_full  = r_count == (PW+1)'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (PW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> src/lbps_back.sv
`timescale 1ns / 1ps

module lbps_back #(
    parameter int NUM_LEDS  = lbps_pkg::NUM_LEDS_DEF,
    parameter int MAX_SLOTS = lbps_pkg::MAX_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  lbps_pkg::t_cmd                   i_q_cmd,
    output logic                             o_q_pop,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [lbps_pkg::OUT_TDATA_W-1:0] o_tdata
);

    localparam int LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int MEM_DEPTH = NUM_LEDS * MAX_SLOTS;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int DW        = lbps_pkg::DUR_W;
    localparam int PW        = lbps_pkg::PINS_W;

    // Per-LED state.
    lbps_pkg::t_mode     r_mode  [NUM_LEDS];
    lbps_pkg::t_mode     n_mode  [NUM_LEDS];
    logic [CNT_W-1:0]    r_cnt   [NUM_LEDS];
    logic [CNT_W-1:0]    n_cnt   [NUM_LEDS];
    logic [SLOT_W-1:0]   r_sidx  [NUM_LEDS];
    logic [SLOT_W-1:0]   n_sidx  [NUM_LEDS];
    logic [DW-1:0]       r_rem   [NUM_LEDS];
    logic [DW-1:0]       n_rem   [NUM_LEDS];
    logic [NUM_LEDS-1:0] r_first, n_first;
    logic [NUM_LEDS-1:0] r_pin,   n_pin;

    lbps_pkg::t_state    r_state, n_state;
    logic [LED_W-1:0]    r_walk,  n_walk;

    logic                r_out_valid, n_out_valid;
    logic [PW-1:0]       r_out_pins,  n_out_pins;

    // Pattern store, one row of MAX_SLOTS durations per LED.
    logic [DW-1:0]       r_store [MEM_DEPTH];
    logic [DW-1:0]       r_rd_data;
    logic                w_mem_we;
    logic                w_mem_re;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [ADDR_W-1:0]   w_rd_addr;

    logic [LED_W+1:0]    w_led_ext;
    logic [LED_W-1:0]    w_led;
    logic [CNT_W:0]      w_nxt;
    logic [SLOT_W-1:0]   w_new_idx;
    logic                w_advance;
    logic [NUM_LEDS+3:0] w_pin_ext;

    assign w_led_ext = (LED_W+2)'(i_q_cmd.led);
    assign w_led     = w_led_ext[LED_W-1:0];
    assign w_pin_ext = (NUM_LEDS+4)'(r_pin);
    assign w_wr_addr = ADDR_W'(w_led * MAX_SLOTS + i_q_cmd.slot);
    assign w_rd_addr = ADDR_W'(r_walk * MAX_SLOTS + w_new_idx);

    // Slot that the walked LED enters when its current slot runs out.
    always_comb begin
        w_nxt = (CNT_W+1)'(r_sidx[r_walk]) + (CNT_W+1)'(1);
        if (r_first[r_walk]) begin
            w_new_idx = '0;
        end else if (w_nxt >= (CNT_W+1)'(r_cnt[r_walk]) ||
                     w_nxt >= (CNT_W+1)'(MAX_SLOTS)) begin
            w_new_idx = '0;
        end else begin
            w_new_idx = w_nxt[SLOT_W-1:0];
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_sidx      = r_sidx;
        n_rem       = r_rem;
        n_first     = r_first;
        n_pin       = r_pin;
        n_state     = r_state;
        n_walk      = r_walk;
        n_out_valid = r_out_valid && !i_tready;
        n_out_pins  = r_out_pins;
        o_q_pop     = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_advance   = 1'b0;

        case (r_state)
            lbps_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = lbps_pkg::S_EMIT;
                    case (i_q_cmd.kind)
                        lbps_pkg::K_TICK: begin
                            n_walk  = '0;
                            n_state = lbps_pkg::S_TICK_CALC;
                        end
                        lbps_pkg::K_ON: begin
                            n_mode[w_led] = lbps_pkg::MODE_ON;
                            n_pin[w_led]  = 1'b0;
                        end
                        lbps_pkg::K_OFF: begin
                            n_mode[w_led] = lbps_pkg::MODE_OFF;
                            n_pin[w_led]  = 1'b1;
                        end
                        lbps_pkg::K_TOGGLE: begin
                            if (r_mode[w_led] == lbps_pkg::MODE_ON) begin
                                n_mode[w_led] = lbps_pkg::MODE_OFF;
                                n_pin[w_led]  = 1'b1;
                            end else begin
                                n_mode[w_led] = lbps_pkg::MODE_ON;
                                n_pin[w_led]  = 1'b0;
                            end
                        end
                        lbps_pkg::K_ALL_ON: begin
                            for (int i = 0; i < NUM_LEDS; i++) begin
                                n_mode[i] = lbps_pkg::MODE_ON;
                            end
                            n_pin = '0;
                        end
                        lbps_pkg::K_ALL_OFF: begin
                            for (int i = 0; i < NUM_LEDS; i++) begin
                                n_mode[i] = lbps_pkg::MODE_OFF;
                            end
                            n_pin = '1;
                        end
                        lbps_pkg::K_WRITE: begin
                            w_mem_we = 1'b1;
                        end
                        lbps_pkg::K_BLINK: begin
                            n_mode[w_led]  = lbps_pkg::MODE_BLINK;
                            n_cnt[w_led]   = i_q_cmd.count[CNT_W-1:0];
                            n_sidx[w_led]  = '0;
                            n_rem[w_led]   = '0;
                            n_first[w_led] = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lbps_pkg::S_TICK_CALC: begin
                if (r_mode[r_walk] != lbps_pkg::MODE_BLINK) begin
                    w_advance = 1'b1;
                end else if (!r_first[r_walk] && r_rem[r_walk] != '0) begin
                    n_rem[r_walk] = r_rem[r_walk] - DW'(1);
                    w_advance     = 1'b1;
                end else begin
                    // Enter the next slot; its duration arrives from the store next cycle.
                    n_sidx[r_walk]  = w_new_idx;
                    n_pin[r_walk]   = w_new_idx[0];
                    n_first[r_walk] = 1'b0;
                    w_mem_re        = 1'b1;
                    n_state         = lbps_pkg::S_TICK_LOAD;
                end
            end
            lbps_pkg::S_TICK_LOAD: begin
                n_rem[r_walk] = r_rd_data;
                n_state       = lbps_pkg::S_TICK_CALC;
                w_advance     = 1'b1;
            end
            lbps_pkg::S_EMIT: begin
                if (!r_out_valid || i_tready) begin
                    n_out_valid = 1'b1;
                    n_out_pins  = w_pin_ext[PW-1:0];
                    n_state     = lbps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lbps_pkg::S_IDLE;
            end
        endcase

        if (w_advance) begin
            if (r_walk == LED_W'(NUM_LEDS - 1)) begin
                n_state = lbps_pkg::S_EMIT;
            end else begin
                n_walk = r_walk + LED_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_mode[i] <= lbps_pkg::MODE_OFF;
                r_cnt[i]  <= '0;
                r_sidx[i] <= '0;
                r_rem[i]  <= '0;
            end
            r_first     <= '0;
            r_pin       <= '1;
            r_state     <= lbps_pkg::S_IDLE;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_cnt       <= n_cnt;
            r_sidx      <= n_sidx;
            r_rem       <= n_rem;
            r_first     <= n_first;
            r_pin       <= n_pin;
            r_state     <= n_state;
            r_walk      <= n_walk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pins <= n_out_pins;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_store[w_wr_addr] <= i_q_cmd.duration;
        end
        if (w_mem_re) begin
            r_rd_data <= r_store[w_rd_addr];
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = lbps_pkg::OUT_TDATA_W'(r_out_pins);

`ifndef SYNTHESIS
    a_load_after_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lbps_pkg::S_TICK_LOAD |-> $past(r_state) == lbps_pkg::S_TICK_CALC)
        else $error("store read data used without a preceding read");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lbps_pkg::S_TICK_LOAD |-> CNT_W'(r_sidx[r_walk]) < r_cnt[r_walk])
        else $error("blinking LED entered a slot beyond its count");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbps_pkg::S_EMIT && (!r_out_valid || i_tready)) |=> r_out_valid)
        else $error("finished command did not produce a result");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == lbps_pkg::S_IDLE && !i_q_empty))
        else $error("command popped outside idle or from an empty queue");
`endif

endmodule

>>> src/led_blink_pattern_sequencer.sv
`timescale 1ns / 1ps

// LED blink pattern sequencer.
// Commands arrive on the s_axis channel, one per transfer; every command
// produces exactly one result transfer on the m_axis channel carrying the
// pin levels of LEDs 0 to 3 (1 dark, 0 lit) after the command took effect.
// A front end decodes and checks each command and writes it into a
// two-entry queue; a back end executes queued commands one at a time.
// A non-tick command passes through the queue and then the back end's idle
// and emit states. A tick walks the LEDs one per cycle, and an LED that
// changes slot also passes through the load state to read its new
// duration from the pattern store. That walk sets the tick rate.
// The pattern store is written only when idle and read only in the walk.
// Reset turns all LEDs off (pins high) and empties the queue and the
// output register; pattern durations are unknown until written.
// When the receiver stalls, the result waits in the output register, the
// back end holds the next result, and the queue keeps accepting commands
// until it is full, after which s_axis_tready drops.
module led_blink_pattern_sequencer #(
    parameter int NUM_LEDS  = lbps_pkg::NUM_LEDS_DEF,
    parameter int MAX_SLOTS = lbps_pkg::MAX_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // From bit 0: op[2:0], led[4:3], slot[8:5], duration[24:9], count[28:25],
    // zero padding [31:29].
    input  logic [lbps_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // From bit 0: pin_levels[3:0], zero padding [7:4].
    output logic [lbps_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;
    lbps_pkg::t_cmd w_push_cmd;
    lbps_pkg::t_cmd w_head_cmd;

    // Decodes op codes, turns commands that address a missing LED or slot
    // into pin reports, and clamps the blink slot count.
    lbps_front #(
        .NUM_LEDS  (NUM_LEDS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_q_full (w_full),
        .o_q_push (w_push),
        .o_q_cmd  (w_push_cmd)
    );

    lbps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head_cmd)
    );

    // Holds the LED state and pattern store and runs the tick walk.
    lbps_back #(
        .NUM_LEDS  (NUM_LEDS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_cmd   (w_head_cmd),
        .o_q_pop   (w_pop),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata)
    );

endmodule
